// ----- src/storm_keyword_spotter_macros.svh -----
// Assertion macros used by the checker.
`ifndef STORM_KEYWORD_SPOTTER_MACROS_SVH
`define STORM_KEYWORD_SPOTTER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SKW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("skw: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define SKW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("skw: next-cycle check failed");

`endif

// ----- src/skw_pkg.sv -----
`timescale 1ns / 1ps

package skw_pkg;

    localparam int HISTORY_BYTES = 15;
    localparam int HIST_IDX_W    = $clog2(HISTORY_BYTES);
    localparam int KW_COUNT      = 13;
    localparam int KW_MAX        = 15;
    localparam int WIN_W         = 12;

    typedef logic [7:0] byte_t;
    typedef logic [3:0] kw_len_t;
    typedef logic [WIN_W-1:0] win_t;
    typedef logic [HISTORY_BYTES-1:0][7:0] hist_t;

    typedef struct packed {
        logic kw_hit;
        logic lei_tail;
        logic yu_tail;
    } match_t;

    localparam win_t  WINDOW_RESET = win_t'(100);
    localparam win_t  CNT_MAX      = '1;
    localparam byte_t UPPER_A      = 8'h41;
    localparam byte_t UPPER_Z      = 8'h5A;
    localparam byte_t CASE_OFFSET  = 8'h20;
    localparam byte_t END_BYTE     = 8'h00;

    localparam logic [23:0] LEI_SEQ = 24'hE99BB7;
    localparam logic [23:0] YU_SEQ  = 24'hE99BA8;

    localparam kw_len_t KW_LEN [KW_COUNT] = '{
        4'd7, 4'd9, 4'd5, 4'd10, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd9, 4'd15, 4'd6
    };

    // Oldest byte first, zero padded.
    localparam byte_t KW_BYTES [KW_COUNT][KW_MAX] = '{
        '{8'h74, 8'h68, 8'h75, 8'h6E, 8'h64, 8'h65, 8'h72, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h6C, 8'h69, 8'h67, 8'h68, 8'h74, 8'h6E, 8'h69, 8'h6E,
          8'h67, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h73, 8'h74, 8'h6F, 8'h72, 8'h6D, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h68, 8'h65, 8'h61, 8'h76, 8'h79, 8'h20, 8'h72, 8'h61,
          8'h69, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hE9, 8'h9B, 8'hB7, 8'hE9, 8'h9B, 8'hA8, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hE9, 8'h9B, 8'hB7, 8'hE6, 8'h9A, 8'hB4, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hE6, 8'h9A, 8'hB4, 8'hE9, 8'h9B, 8'hA8, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hE9, 8'h97, 8'hAA, 8'hE7, 8'h94, 8'hB5, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hE9, 8'h9B, 8'hB7, 8'hE7, 8'h94, 8'hB5, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hE6, 8'h89, 8'h93, 8'hE9, 8'h9B, 8'hB7, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hE9, 8'h9B, 8'hB7, 8'hE9, 8'h98, 8'hB5, 8'hE9, 8'h9B,
          8'hA8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hE5, 8'hBC, 8'hBA, 8'hE5, 8'hAF, 8'hB9, 8'hE6, 8'hB5,
          8'h81, 8'hE5, 8'hA4, 8'hA9, 8'hE6, 8'hB0, 8'h94},
        '{8'hE9, 8'h9B, 8'hB7, 8'hE5, 8'h87, 8'hBB, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

endpackage

// ----- src/skw_if.sv -----
`timescale 1ns / 1ps

interface skw_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface skw_out_if;
    logic valid;
    logic ready;
    logic storm_detected;

    modport source (output valid, output storm_detected, input ready);
    modport sink   (input valid, input storm_detected, output ready);
endinterface

// ----- src/skw_cell.sv -----
`timescale 1ns / 1ps

module skw_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          shift_en,
    input  logic          clear,
    input  skw_pkg::byte_t din,
    output skw_pkg::byte_t dout
);
    import skw_pkg::*;

    byte_t data_reg;
    byte_t data_next;

    always_comb
    begin
        data_next = data_reg;
        if (clear)
        begin
            data_next = '0;
        end
        else if (shift_en)
        begin
            data_next = din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign dout = data_reg;
endmodule

// ----- src/skw_match.sv -----
`timescale 1ns / 1ps

// hist[0] is the newest byte.
module skw_match (
    input  skw_pkg::hist_t  hist,
    output skw_pkg::match_t result
);
    import skw_pkg::*;

    logic [KW_COUNT-1:0] kw_match;

    always_comb
    begin
        int age;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            kw_match[k] = (int'(KW_LEN[k]) <= HISTORY_BYTES);
            for (int i = 0; i < KW_MAX; i++)
            begin
                age = int'(KW_LEN[k]) - 1 - i;
                if (i < int'(KW_LEN[k]))
                begin
                    if (hist[age[HIST_IDX_W-1:0]] != KW_BYTES[k][i])
                    begin
                        kw_match[k] = 1'b0;
                    end
                end
            end
        end
    end

    assign result.kw_hit   = |kw_match;
    assign result.lei_tail = ({hist[2], hist[1], hist[0]} == LEI_SEQ);
    assign result.yu_tail  = ({hist[2], hist[1], hist[0]} == YU_SEQ);
endmodule

// ----- src/storm_keyword_spotter.sv -----
// Throughput: one text byte per cycle; input stalls only while a result is held unaccepted.
// Latency: the flag is valid in the cycle after the last byte is accepted.
// The history is a row of byte cells; the incoming byte and the history are compared against the keywords at once.
// Reset: history, flags (but the held output flag) and counter cleared, window_reg set to 100.
// The same text state is cleared again after each last byte.
`timescale 1ns / 1ps

module storm_keyword_spotter (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  skw_pkg::win_t    cfg_wr_data,
    skw_in_if.sink           text_in,
    skw_out_if.source        flag_out
);
    import skw_pkg::*;

    hist_t  hist;
    hist_t  new_hist;
    match_t match;
    byte_t  folded;

    win_t   window_reg;
    win_t   window_next;
    win_t   cnt_reg;
    win_t   cnt_next;
    win_t   cnt_inc;
    logic   hit_reg, hit_next;
    logic   lei_reg, lei_next;
    logic   rain_reg, rain_next;
    logic   ended_reg, ended_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_flag_reg, out_flag_next;

    logic   accept;
    logic   take;
    logic   finish;
    logic   prox_hit;

    assign text_in.ready = !out_valid_reg || flag_out.ready;
    assign accept        = text_in.valid && text_in.ready;
    assign take          = accept && !ended_reg && (text_in.text_byte != END_BYTE);
    assign finish        = accept && text_in.last_byte;

    assign folded = (text_in.text_byte >= UPPER_A && text_in.text_byte <= UPPER_Z)
                  ? text_in.text_byte + CASE_OFFSET : text_in.text_byte;

    always_comb
    begin
        new_hist[0] = folded;
        for (int i = 1; i < HISTORY_BYTES; i++)
        begin
            new_hist[i] = hist[i-1];
        end
    end

    genvar g;
    generate
        for (g = 0; g < HISTORY_BYTES; g++)
        begin : g_cell
            skw_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (take),
                .clear    (finish),
                .din      (new_hist[g]),
                .dout     (hist[g])
            );
        end
    endgenerate

    skw_match u_match (
        .hist   (new_hist),
        .result (match)
    );

    assign cnt_inc  = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + win_t'(1);
    assign prox_hit = lei_reg && !rain_reg && match.yu_tail && (cnt_inc < window_reg);

    always_comb
    begin
        window_next    = cfg_wr_en ? cfg_wr_data : window_reg;
        cnt_next       = cnt_reg;
        hit_next       = hit_reg;
        lei_next       = lei_reg;
        rain_next      = rain_reg;
        ended_next     = ended_reg;
        out_flag_next  = out_flag_reg;
        out_valid_next = out_valid_reg && !flag_out.ready;

        if (accept && !ended_reg && (text_in.text_byte == END_BYTE))
        begin
            ended_next = 1'b1;
        end

        if (take)
        begin
            if (match.kw_hit || prox_hit)
            begin
                hit_next = 1'b1;
            end
            if (lei_reg)
            begin
                cnt_next = cnt_inc;
                if (!rain_reg && match.yu_tail)
                begin
                    rain_next = 1'b1;
                end
            end
            else if (match.lei_tail)
            begin
                lei_next = 1'b1;
                cnt_next = '0;
            end
        end

        if (finish)
        begin
            out_valid_next = 1'b1;
            out_flag_next  = hit_next;
            hit_next       = 1'b0;
            lei_next       = 1'b0;
            rain_next      = 1'b0;
            ended_next     = 1'b0;
            cnt_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= WINDOW_RESET;
            cnt_reg       <= '0;
            hit_reg       <= 1'b0;
            lei_reg       <= 1'b0;
            rain_reg      <= 1'b0;
            ended_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            window_reg    <= window_next;
            cnt_reg       <= cnt_next;
            hit_reg       <= hit_next;
            lei_reg       <= lei_next;
            rain_reg      <= rain_next;
            ended_reg     <= ended_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_flag_reg <= out_flag_next;
    end

    assign flag_out.valid          = out_valid_reg;
    assign flag_out.storm_detected = out_flag_reg;
endmodule

// ----- src/skw_checker.sv -----
`timescale 1ns / 1ps
`include "storm_keyword_spotter_macros.svh"

module skw_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_last,
    input logic out_valid,
    input logic out_ready
);
    logic in_fire;
    logic in_end;

    assign in_fire = in_valid && in_ready;
    assign in_end  = in_fire && in_last;

    // A held result stays offered.
    `SKW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    // A final byte always produces a result transaction.
    `SKW_ASSERT_NEXT(a_end_gives_result, clk, rst_n, in_end, out_valid)
    // A taken result with no new final byte leaves the output empty.
    `SKW_ASSERT_NEXT(a_no_phantom, clk, rst_n, out_valid && out_ready && !in_end, !out_valid)
    // Nothing to deliver means input is open.
    `SKW_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)
endmodule

bind storm_keyword_spotter skw_checker u_skw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (text_in.valid),
    .in_ready  (text_in.ready),
    .in_last   (text_in.last_byte),
    .out_valid (flag_out.valid),
    .out_ready (flag_out.ready)
);
